[rtl/core/pmst_pkg.sv]
`timescale 1ns / 1ps
package pmst_pkg;
    localparam int MAX_NODES = 32;
    localparam int NODE_W = 5;
    localparam int ADDR_W = 2 * NODE_W;
    localparam int WEIGHT_W = 31;
    localparam int COST_W = 32;
    localparam int TOTAL_W = 36;
    localparam int CNT_W = 6;
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_RUN = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [COST_W-1:0] UNREACHED = '1;
    localparam int IN_W = 48;
    localparam int OUT_W = 80;
endpackage

[rtl/core/pmst_ram.sv]
`timescale 1ns / 1ps
module pmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/core/prim_mst_dense.sv]
`timescale 1ns / 1ps
// channel   | dir | tdata fields (low bit first)                               | tuser
// s_axis    | in  | mode, node_a, node_b, weight (pad to 48)                   | -
// m_axis    | out | node, parent, edge_weight, total_cost, no_tree (pad to 80) | tlast = last
// edge write: two matrix writes (mirror), clear: a sweep over the whole matrix
// run: per joined node a selection scan, a pick, a result item (none for node 0)
// and n matrix reads, for node_count n
// reset clears control only; the matrix is cleared by a full sweep after
// reset, input not taken meanwhile; config writes accepted at any time
// a stalled result holds the engine until m_axis_tready
module prim_mst_dense
    import pmst_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CNT_W-1:0]     cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,   // mode, node_a, node_b, weight
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata,   // node, parent, edge_weight, total_cost, no_tree
    output logic                 m_axis_tlast
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WR2, S_INIT, S_SEL, S_PICK, S_REL, S_RELW, S_OUT, S_SUM
    } state_t;

    state_t                   state_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [ADDR_W-1:0]        clr_reg;
    logic [NODE_W-1:0]        a_reg, b_reg;
    logic [WEIGHT_W-1:0]      w_reg;
    logic [MAX_NODES-1:0]     tree_reg;
    logic [COST_W-1:0]        cost_reg [MAX_NODES];
    logic [NODE_W-1:0]        par_reg [MAX_NODES];
    logic [CNT_W-1:0]         n_reg, j_reg;
    logic [NODE_W-1:0]        v_reg;
    logic                     found_reg;
    logic [TOTAL_W-1:0]       total_reg;
    logic                     ovalid_reg;
    logic [OUT_W-1:0]         odata_reg;
    logic                     olast_reg;

    logic                     we;
    logic [ADDR_W-1:0]        waddr, raddr;
    logic [WEIGHT_W-1:0]      wdata, rdata;
    logic [NODE_W-1:0]        jj;

    assign jj = j_reg[NODE_W-1:0];

    pmst_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_NODES * MAX_NODES)) u_mat (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    always_comb begin
        we = 1'b0;
        waddr = clr_reg;
        wdata = '0;
        raddr = {v_reg, jj};
        case (state_reg)
            S_CLEAR: we = 1'b1;
            S_IDLE: begin
                we = s_axis_tvalid && s_axis_tdata[1:0] == MODE_WRITE;
                waddr = {s_axis_tdata[6:2], s_axis_tdata[11:7]};
                wdata = s_axis_tdata[42:12];
            end
            S_WR2: begin
                we = 1'b1;
                waddr = {b_reg, a_reg};
                wdata = w_reg;
            end
            default: ;
        endcase
    end

    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = odata_reg;
    assign m_axis_tlast = olast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            ovalid_reg <= 1'b0;
            cnt_reg <= CNT_W'(MAX_NODES);
        end else begin
            if (cfg_we) begin
                cnt_reg <= cfg_wdata;
            end
            if (ovalid_reg && m_axis_tready) begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    a_reg <= s_axis_tdata[6:2];
                    b_reg <= s_axis_tdata[11:7];
                    w_reg <= s_axis_tdata[42:12];
                    if (s_axis_tvalid) begin
                        unique case (s_axis_tdata[1:0])
                            MODE_WRITE: state_reg <= S_WR2;
                            MODE_CLEAR: begin
                                clr_reg <= '0;
                                state_reg <= S_CLEAR;
                            end
                            MODE_RUN: begin
                                if (cnt_reg == '0) begin
                                    n_reg <= CNT_W'(1);
                                end else if (cnt_reg > CNT_W'(MAX_NODES)) begin
                                    n_reg <= CNT_W'(MAX_NODES);
                                end else begin
                                    n_reg <= cnt_reg;
                                end
                                state_reg <= S_INIT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_WR2: state_reg <= S_IDLE;
                S_INIT: begin
                    for (int i = 0; i < MAX_NODES; i++) begin
                        tree_reg[i] <= 1'b0;
                        cost_reg[i] <= (i == 0) ? '0 : UNREACHED;
                        par_reg[i] <= '0;
                    end
                    total_reg <= '0;
                    j_reg <= '0;
                    found_reg <= 1'b0;
                    v_reg <= '0;
                    state_reg <= S_SEL;
                end
                S_SEL: begin
                    if (j_reg == n_reg) begin
                        state_reg <= S_PICK;
                    end else begin
                        if (!tree_reg[jj] && (!found_reg || cost_reg[jj] < cost_reg[v_reg])) begin
                            v_reg <= jj;
                            found_reg <= 1'b1;
                        end
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_PICK: begin
                    if (!found_reg) begin
                        state_reg <= S_SUM;
                    end else if (cost_reg[v_reg] == UNREACHED) begin
                        if (!ovalid_reg || m_axis_tready) begin
                            ovalid_reg <= 1'b1;
                            odata_reg <= {2'b00, 1'b1, TOTAL_W'(0), WEIGHT_W'(0),
                                          NODE_W'(0), NODE_W'(0)};
                            olast_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end else begin
                        tree_reg[v_reg] <= 1'b1;
                        j_reg <= '0;
                        state_reg <= (v_reg != '0) ? S_OUT : S_REL;
                    end
                end
                S_OUT: begin
                    if (!ovalid_reg || m_axis_tready) begin
                        total_reg <= total_reg + TOTAL_W'(cost_reg[v_reg]);
                        ovalid_reg <= 1'b1;
                        odata_reg <= {3'b000, TOTAL_W'(0), cost_reg[v_reg][WEIGHT_W-1:0],
                                      par_reg[v_reg], v_reg};
                        olast_reg <= 1'b0;
                        state_reg <= S_REL;
                    end
                end
                S_REL: begin
                    state_reg <= S_RELW;
                end
                S_RELW: begin
                    if (!tree_reg[jj] && rdata != '0 && COST_W'(rdata) < cost_reg[jj]) begin
                        cost_reg[jj] <= COST_W'(rdata);
                        par_reg[jj] <= v_reg;
                    end
                    if (j_reg == n_reg - 1'b1) begin
                        j_reg <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_SEL;
                    end else begin
                        j_reg <= j_reg + 1'b1;
                        state_reg <= S_REL;
                    end
                end
                S_SUM: begin
                    if (!ovalid_reg || m_axis_tready) begin
                        ovalid_reg <= 1'b1;
                        odata_reg <= {3'b000, total_reg, WEIGHT_W'(0), NODE_W'(0), NODE_W'(0)};
                        olast_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ovalid_reg && !m_axis_tready |=> ovalid_reg && $stable(odata_reg))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !s_axis_tready)
        else $error("input taken while busy");
    a_mirror: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE && s_axis_tvalid && s_axis_tdata[1:0] == MODE_WRITE
        |=> state_reg == S_WR2)
        else $error("mirror write skipped");
`endif
endmodule

[bench/tb_prim_mst_dense.sv]
`timescale 1ns / 1ps
module tb_prim_mst_dense;
    import pmst_pkg::*;

    typedef struct packed {
        logic [1:0]          mode;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [WEIGHT_W-1:0] weight;
    } graph_cmd_t;

    typedef struct packed {
        logic [NODE_W-1:0]   node;
        logic [NODE_W-1:0]   parent;
        logic [WEIGHT_W-1:0] edge_weight;
        logic [TOTAL_W-1:0]  total_cost;
        logic                no_tree;
        logic                last;
    } tree_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;   // mode, node_a, node_b, weight
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;       // node, parent, edge_weight, total_cost, no_tree
    logic m_axis_tlast;

    prim_mst_dense dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    graph_cmd_t pending_cmds[$];
    tree_item_t expected_tree[$];
    logic [WEIGHT_W-1:0] edge_w[MAX_NODES][MAX_NODES];
    logic [CNT_W-1:0] node_count_reg = 6'd32;
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;

    function automatic tree_item_t mk_item(int v, int p, longint w, longint t, bit nt,
                                           bit fin);
        tree_item_t r;
        r.node = NODE_W'(v);
        r.parent = NODE_W'(p);
        r.edge_weight = WEIGHT_W'(w);
        r.total_cost = TOTAL_W'(t);
        r.no_tree = nt;
        r.last = fin;
        return r;
    endfunction

    task automatic add_expected(tree_item_t t);
        expected_tree = {expected_tree, t};
    endtask

    task automatic add_cmd(graph_cmd_t c);
        pending_cmds = {pending_cmds, c};
    endtask

    // prim over the first n nodes, lowest index wins ties
    task automatic predict_tree();
        int n;
        bit joined[MAX_NODES];
        logic [COST_W-1:0] cost[MAX_NODES];
        int par[MAX_NODES];
        logic [TOTAL_W-1:0] total;
        int v;
        bit found;
        n = node_count_reg;
        if (n < 1) n = 1;
        if (n > MAX_NODES) n = MAX_NODES;
        for (int i = 0; i < n; i++) begin
            joined[i] = 0;
            cost[i] = UNREACHED;
            par[i] = 0;
        end
        cost[0] = 0;
        total = 0;
        for (int i = 0; i < n; i++) begin
            v = 0;
            found = 0;
            for (int j = 0; j < n; j++)
                if (!joined[j] && (!found || cost[j] < cost[v])) begin
                    v = j;
                    found = 1;
                end
            if (cost[v] == UNREACHED) begin
                add_expected(mk_item(0, 0, 0, 0, 1, 1));
                return;
            end
            joined[v] = 1;
            if (v != 0) begin
                total = total + TOTAL_W'(cost[v]);
                add_expected(mk_item(v, par[v], cost[v], 0, 0, 0));
            end
            for (int j = 0; j < n; j++)
                if (!joined[j] && edge_w[v][j] != 0 && {1'b0, edge_w[v][j]} < cost[j]) begin
                    cost[j] = COST_W'(edge_w[v][j]);
                    par[j] = v;
                end
        end
        add_expected(mk_item(0, 0, 0, total, 0, 1));
    endtask

    task automatic apply_cmd(graph_cmd_t c);
        case (c.mode)
            MODE_WRITE: begin
                edge_w[c.node_a][c.node_b] = c.weight;
                edge_w[c.node_b][c.node_a] = c.weight;
            end
            MODE_CLEAR: begin
                for (int i = 0; i < MAX_NODES; i++)
                    for (int j = 0; j < MAX_NODES; j++) edge_w[i][j] = '0;
            end
            MODE_RUN: predict_tree();
            default: ;
        endcase
    endtask

    function automatic graph_cmd_t cmd(logic [1:0] m, longint a, longint b, longint w);
        graph_cmd_t c;
        c.mode = m;
        c.node_a = NODE_W'(a);
        c.node_b = NODE_W'(b);
        c.weight = WEIGHT_W'(w);
        return c;
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return 31'd0;
            2: return WEIGHT_W'($urandom);
            default: return WEIGHT_W'($urandom_range(1, 6));
        endcase
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                graph_cmd_t c;
                c = pending_cmds.pop_front();
                apply_cmd(c);
                s_axis_tdata <= {{(IN_W - 43){1'b0}}, c.weight, c.node_b, c.node_a, c.mode};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold
    always @(posedge aclk) begin
        if (hold_go && !hold_done) begin
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles == 2999) hold_done <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (hold_go && !hold_done) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= aresetn && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            tree_item_t got, want;
            got = {m_axis_tdata[NODE_W-1:0], m_axis_tdata[2*NODE_W-1:NODE_W],
                   m_axis_tdata[2*NODE_W+WEIGHT_W-1:2*NODE_W],
                   m_axis_tdata[2*NODE_W+WEIGHT_W+TOTAL_W-1:2*NODE_W+WEIGHT_W],
                   m_axis_tdata[2*NODE_W+WEIGHT_W+TOTAL_W], m_axis_tlast};
            if (expected_tree.size() == 0) begin
                $error("unexpected result item %h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_tree.pop_front();
                if (got.node !== want.node) begin
                    $error("node exp %0d got %0d", want.node, got.node); errors++;
                end
                if (got.parent !== want.parent) begin
                    $error("parent exp %0d got %0d", want.parent, got.parent); errors++;
                end
                if (got.edge_weight !== want.edge_weight) begin
                    $error("edge_weight exp %0d got %0d", want.edge_weight, got.edge_weight);
                    errors++;
                end
                if (got.total_cost !== want.total_cost) begin
                    $error("total_cost exp %0d got %0d", want.total_cost, got.total_cost);
                    errors++;
                end
                if (got.no_tree !== want.no_tree) begin
                    $error("no_tree exp %0d got %0d", want.no_tree, got.no_tree); errors++;
                end
                if (got.last !== want.last) begin
                    $error("last exp %0d got %0d", want.last, got.last); errors++;
                end
            end
        end
    end

    task automatic drain();
        while (pending_cmds.size() > 0 || s_axis_tvalid || expected_tree.size() > 0)
            @(posedge aclk);
        repeat (2200) @(posedge aclk);
    endtask

    task automatic set_nodes(int n);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= CNT_W'(n);
        @(posedge aclk);
        cfg_we <= 1'b0;
        node_count_reg = CNT_W'(n);
    endtask

    // a random graph, mostly connected through a random spanning tree
    task automatic queue_graph(int n);
        int k;
        add_cmd(cmd(MODE_CLEAR, 0, 0, 0));
        if ($urandom_range(0, 3) != 0)
            for (int i = 1; i < n; i++)
                add_cmd(cmd(MODE_WRITE, $urandom_range(0, i - 1), i, $urandom_range(1, 9)));
        k = $urandom_range(0, 6);
        for (int i = 0; i < k; i++)
            add_cmd(cmd(MODE_WRITE, $urandom_range(0, 31), $urandom_range(0, 31),
                        rand_weight()));
        if ($urandom_range(0, 5) == 0)
            add_cmd(cmd(MODE_UNUSED, $urandom, $urandom, $urandom));
        add_cmd(cmd(MODE_RUN, $urandom, $urandom, $urandom));
    endtask

    initial begin
        int sizes[7] = '{32, 1, 0, 2, 5, 63, 8};
        for (int i = 0; i < MAX_NODES; i++)
            for (int j = 0; j < MAX_NODES; j++) edge_w[i][j] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (1100) @(posedge aclk);
        // directed: reset size 32, empty graph, then extremes
        add_cmd(cmd(MODE_RUN, 0, 0, 0));
        add_cmd(cmd(MODE_WRITE, 0, 31, 31'h7fffffff));
        add_cmd(cmd(MODE_WRITE, 5, 5, 1));
        add_cmd(cmd(MODE_UNUSED, 31, 31, 31'h7fffffff));
        for (int i = 1; i < 31; i++)
            if (i != 5) add_cmd(cmd(MODE_WRITE, i, i + 1, 2));
        add_cmd(cmd(MODE_WRITE, 5, 4, 2));
        add_cmd(cmd(MODE_WRITE, 5, 6, 2));
        add_cmd(cmd(MODE_WRITE, 0, 1, 2));
        add_cmd(cmd(MODE_WRITE, 0, 2, 2));
        add_cmd(cmd(MODE_RUN, 0, 0, 0));
        hold_go <= 1'b1;
        drain();
        for (int ph = 0; ph < 8; ph++) begin
            int n;
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 73; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 73; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            n = (ph < 7) ? sizes[ph] : $urandom_range(1, 10);
            set_nodes(n);
            if (n < 1) n = 1;
            if (n > 32) n = 32;
            queue_graph(n);
            queue_graph(n);
            drain();
        end
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
